// ===== sv/equatorial_pointing_correction_defines.svh =====
// assertion macros for the equatorial pointing correction block
// no dependencies; included by files that carry concurrent checks
`ifndef EQUATORIAL_POINTING_CORRECTION_DEFINES_SVH
`define EQUATORIAL_POINTING_CORRECTION_DEFINES_SVH
`ifndef SYNTHESIS
// check sampled on aclk, off while reset is asserted
`define EPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("epc check failed");
// check sampled on aclk, also active during reset
`define EPC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("epc check failed");
`else
`define EPC_ASSERT(lbl, prop)
`define EPC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== sv/epc_pkg.sv =====
// shared types, constants and arithmetic helpers of the pointing correction block
// no dependencies; used by all modules of the block
package epc_pkg;

    localparam int ANGLE_WIDTH_DEF   = 32;
    localparam int COEF_WIDTH_DEF    = 32;
    localparam int CORDIC_STAGES_DEF = 30;

    localparam int ROT_W   = 34;
    localparam int QUOT_W  = 31;
    // holds the divisor shifted up by the top quotient bit
    localparam int REM_W   = 62;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [63:0]      INV_PI_Q32  = 64'sd1367130551;
    localparam logic [QUOT_W-1:0]       COS_MIN     = 31'd16777216;
    localparam logic signed [31:0]      TRIG_SAT    = 32'sd1073741824;

    typedef enum logic [2:0] {
        CFG_INDEX_OFFSETS  = 3'd0,
        CFG_POLAR_AXIS     = 3'd1,
        CFG_FLEXURE        = 3'd2,
        CFG_COLLIMATION    = 3'd3,
        CFG_FORK_FLEXURE   = 3'd4,
        CFG_SITE_LATITUDE  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic               mode;
        logic [31:0]        right_ascension;
        logic signed [31:0] declination;
    } in_t;

    typedef struct packed {
        logic [31:0]        corrected_ra;
        logic signed [31:0] corrected_dec;
        logic               pole_saturated;
    } out_t;

    // one rotator of the cordic row
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic                    flip;
    } rot_t;

    // everything that travels down the cordic row
    typedef struct packed {
        rot_t               h;
        rot_t               d;
        rot_t               p;
        logic               mode;
        logic [31:0]        ra;
        logic signed [31:0] dec;
    } crow_t;

    // side data that rides along the divider row
    typedef struct packed {
        logic               mode;
        logic [31:0]        ra;
        logic signed [31:0] dec;
        logic signed [31:0] ch;
        logic signed [31:0] sh;
        logic signed [31:0] cd;
        logic signed [31:0] sd;
        logic signed [31:0] cp;
        logic signed [31:0] sp;
        logic               sat;
        logic               sec_neg;
        logic               tn_neg;
    } dside_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem_s;
        logic [REM_W-1:0]  rem_t;
        logic [QUOT_W-1:0] den;
        logic [QUOT_W-1:0] q_s;
        logic [QUOT_W-1:0] q_t;
        dside_t            side;
    } drow_t;

    // arctangent of 2^-i in turn units
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // product rounded half up, then floor shift
    function automatic logic signed [63:0] mul_rnd(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int unsigned s);
        logic signed [63:0] p;
        p = a * b;
        return (p + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // coefficient field to turn units
    function automatic logic signed [31:0] coef_turn(input logic [31:0] half,
                                                     input int unsigned cw);
        logic signed [31:0] c;
        logic signed [63:0] p;
        c = $signed(half << (32 - cw));
        p = 64'(c) * INV_PI_Q32;
        return 32'((p + (64'sd1 <<< 31)) >>> 32);
    endfunction

endpackage

// ===== sv/equatorial_pointing_correction.sv =====
// Equatorial pointing correction. Takes one position per clock cycle while the skid entry
// is empty; each transaction flows through CORDIC_STAGES cordic cells, one conditioning
// stage, 31 divider cells for secant and tangent, one stage to sign them, four multiply
// stages and the output register. The cordic row and the divider row are the longest
// parts of the pipeline. A two-entry output (register plus skid) keeps the input open
// while one result waits. Written coefficients pass a registered turn-unit conversion.
// depends on epc_pkg, epc_cordic_cell, epc_div_cell and the defines header
`include "equatorial_pointing_correction_defines.svh"
module equatorial_pointing_correction #(
    parameter int ANGLE_WIDTH   = epc_pkg::ANGLE_WIDTH_DEF,
    parameter int COEF_WIDTH    = epc_pkg::COEF_WIDTH_DEF,
    parameter int CORDIC_STAGES = epc_pkg::CORDIC_STAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  epc_pkg::in_t s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output epc_pkg::out_t m_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int MASK_BITS = (ANGLE_WIDTH < 32) ? (32 - ANGLE_WIDTH) : 0;
    localparam logic [31:0] ANGLE_MASK = 32'hFFFF_FFFF << MASK_BITS;
    localparam int QW = epc_pkg::QUOT_W;

    // configuration registers
    logic [63:0] idx_reg, pa_reg, flex_reg, coll_reg;
    logic [31:0] fork_reg, lat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            pa_reg   <= '0;
            flex_reg <= '0;
            coll_reg <= '0;
            fork_reg <= '0;
            lat_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (epc_pkg::cfg_index_t'(cfg_index))
                epc_pkg::CFG_INDEX_OFFSETS: idx_reg  <= cfg_data;
                epc_pkg::CFG_POLAR_AXIS:    pa_reg   <= cfg_data;
                epc_pkg::CFG_FLEXURE:       flex_reg <= cfg_data;
                epc_pkg::CFG_COLLIMATION:   coll_reg <= cfg_data;
                epc_pkg::CFG_FORK_FLEXURE:  fork_reg <= cfg_data[31:0];
                epc_pkg::CFG_SITE_LATITUDE: lat_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // coefficients in turn units
    logic signed [31:0] ixd_reg, ixr_reg, pa1_reg, pa2_reg, tf_reg, dc_reg;
    logic signed [31:0] co_reg, np_reg, fo_reg;

    always_ff @(posedge aclk) begin
        ixd_reg <= epc_pkg::coef_turn(idx_reg[63:32], COEF_WIDTH);
        ixr_reg <= epc_pkg::coef_turn(idx_reg[31:0], COEF_WIDTH);
        pa1_reg <= epc_pkg::coef_turn(pa_reg[63:32], COEF_WIDTH);
        pa2_reg <= epc_pkg::coef_turn(pa_reg[31:0], COEF_WIDTH);
        tf_reg  <= epc_pkg::coef_turn(flex_reg[63:32], COEF_WIDTH);
        dc_reg  <= epc_pkg::coef_turn(flex_reg[31:0], COEF_WIDTH);
        co_reg  <= epc_pkg::coef_turn(coll_reg[63:32], COEF_WIDTH);
        np_reg  <= epc_pkg::coef_turn(coll_reg[31:0], COEF_WIDTH);
        fo_reg  <= epc_pkg::coef_turn(fork_reg, COEF_WIDTH);
    end

    // pipeline advance and output buffering
    logic   en;
    logic   m_valid_reg, skid_valid_reg;
    epc_pkg::out_t m_data_reg, skid_data_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // quadrant fold ahead of the cordic row
    function automatic epc_pkg::rot_t prep(input logic [31:0] a);
        epc_pkg::rot_t r;
        logic [31:0] am;
        am     = a & ANGLE_MASK;
        r.flip = am[31] ^ am[30];
        if (r.flip) begin
            am = am + 32'h8000_0000;
        end
        r.x = epc_pkg::CORDIC_GAIN;
        r.y = '0;
        r.z = $signed({{2{am[31]}}, am});
        return r;
    endfunction

    epc_pkg::crow_t crow [CORDIC_STAGES+1];
    logic           cval [CORDIC_STAGES+1];

    assign crow[0].h    = prep(s_data.right_ascension);
    assign crow[0].d    = prep(s_data.declination);
    assign crow[0].p    = prep(lat_reg);
    assign crow[0].mode = s_data.mode;
    assign crow[0].ra   = s_data.right_ascension;
    assign crow[0].dec  = s_data.declination;
    assign cval[0]      = s_valid && en;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        epc_cordic_cell #(.STAGE(i)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (cval[i]),
            .in_row   (crow[i]),
            .out_valid(cval[i+1]),
            .out_row  (crow[i+1])
        );
    end

    // unfold results, form divider operands
    function automatic logic signed [epc_pkg::ROT_W-1:0] unfold(
        input logic signed [epc_pkg::ROT_W-1:0] v, input logic flip);
        return flip ? -v : v;
    endfunction

    epc_pkg::drow_t drow [QW+1];
    logic           dval [QW+1];
    epc_pkg::drow_t d0_next;
    logic signed [epc_pkg::ROT_W-1:0] cd_w, sd_w;
    logic [QW-1:0] ac_w, as_w;

    always_comb begin
        cd_w = unfold(crow[CORDIC_STAGES].d.x, crow[CORDIC_STAGES].d.flip);
        sd_w = unfold(crow[CORDIC_STAGES].d.y, crow[CORDIC_STAGES].d.flip);
        ac_w = cd_w[epc_pkg::ROT_W-1] ? QW'(-cd_w) : QW'(cd_w);
        as_w = sd_w[epc_pkg::ROT_W-1] ? QW'(-sd_w) : QW'(sd_w);
        d0_next.side.mode = crow[CORDIC_STAGES].mode;
        d0_next.side.ra   = crow[CORDIC_STAGES].ra;
        d0_next.side.dec  = crow[CORDIC_STAGES].dec;
        d0_next.side.ch   = 32'(unfold(crow[CORDIC_STAGES].h.x, crow[CORDIC_STAGES].h.flip));
        d0_next.side.sh   = 32'(unfold(crow[CORDIC_STAGES].h.y, crow[CORDIC_STAGES].h.flip));
        d0_next.side.cd   = 32'(cd_w);
        d0_next.side.sd   = 32'(sd_w);
        d0_next.side.cp   = 32'(unfold(crow[CORDIC_STAGES].p.x, crow[CORDIC_STAGES].p.flip));
        d0_next.side.sp   = 32'(unfold(crow[CORDIC_STAGES].p.y, crow[CORDIC_STAGES].p.flip));
        d0_next.side.sat  = ac_w < epc_pkg::COS_MIN;
        d0_next.side.sec_neg = cd_w[epc_pkg::ROT_W-1];
        d0_next.side.tn_neg  = sd_w[epc_pkg::ROT_W-1] ^ cd_w[epc_pkg::ROT_W-1];
        d0_next.den   = ac_w;
        d0_next.rem_s = (epc_pkg::REM_W'(1) << 54) + epc_pkg::REM_W'(ac_w >> 1);
        d0_next.rem_t = (epc_pkg::REM_W'(as_w) << 24) + epc_pkg::REM_W'(ac_w >> 1);
        d0_next.q_s   = '0;
        d0_next.q_t   = '0;
    end

    logic           d0_valid_reg;
    epc_pkg::drow_t d0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_valid_reg <= 1'b0;
        end else if (en) begin
            d0_valid_reg <= cval[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg <= d0_next;
        end
    end

    assign drow[0] = d0_reg;
    assign dval[0] = d0_valid_reg;

    for (genvar j = 0; j < QW; j++) begin : g_div
        epc_div_cell #(.BIT(QW - 1 - j)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (dval[j]),
            .in_row   (drow[j]),
            .out_valid(dval[j+1]),
            .out_row  (drow[j+1])
        );
    end

    // signed secant and tangent, saturated near the pole
    epc_pkg::dside_t sd_side_reg;
    logic signed [31:0] sec_reg, tn_reg;
    logic sg_valid_reg;
    logic signed [31:0] sec_next, tn_next;

    always_comb begin
        sec_next = $signed({1'b0, drow[QW].q_s});
        tn_next  = $signed({1'b0, drow[QW].q_t});
        if (drow[QW].side.sat) begin
            sec_next = epc_pkg::TRIG_SAT;
            tn_next  = epc_pkg::TRIG_SAT;
        end
        if (drow[QW].side.sec_neg) begin
            sec_next = -sec_next;
        end
        if (drow[QW].side.tn_neg) begin
            tn_next = -tn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_side_reg <= drow[QW].side;
            sec_reg     <= sec_next;
            tn_reg      <= tn_next;
        end
    end

    // stage 1: first-level products
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [31:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg;
    logic signed [31:0] p8_reg, p9_reg, p10_reg;
    logic [31:0]        p11_reg, p12_reg;
    logic signed [31:0] ch1_reg, sec1_reg, tn1_reg, dec1_reg;
    logic [31:0]        ra1_reg;
    logic               mode1_reg, sat1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= 32'(epc_pkg::mul_rnd(64'(pa1_reg), 64'(sd_side_reg.ch), 30));
            p2_reg  <= 32'(epc_pkg::mul_rnd(64'(pa2_reg), 64'(sd_side_reg.sh), 30));
            p3_reg  <= 32'(epc_pkg::mul_rnd(64'(dc_reg), 64'(sd_side_reg.ch), 30));
            p4_reg  <= 32'(epc_pkg::mul_rnd(64'(sd_side_reg.cp), 64'(sd_side_reg.sd), 30));
            p5_reg  <= 32'(epc_pkg::mul_rnd(64'(sd_side_reg.sp), 64'(sd_side_reg.cd), 30));
            p6_reg  <= 32'(epc_pkg::mul_rnd(64'(pa1_reg), 64'(sd_side_reg.sh), 30));
            p7_reg  <= 32'(epc_pkg::mul_rnd(64'(pa2_reg), 64'(sd_side_reg.ch), 30));
            p8_reg  <= 32'(epc_pkg::mul_rnd(64'(sd_side_reg.cp), 64'(sd_side_reg.sh), 30));
            p9_reg  <= 32'(epc_pkg::mul_rnd(64'(sd_side_reg.sp), 64'(tn_reg), 30));
            p10_reg <= 32'(epc_pkg::mul_rnd(64'(sd_side_reg.cp), 64'(sd_side_reg.ch), 36));
            p11_reg <= 32'(epc_pkg::mul_rnd(64'(co_reg), 64'(sec_reg), 24));
            p12_reg <= 32'(epc_pkg::mul_rnd(64'(np_reg), 64'(tn_reg), 24));
            ch1_reg   <= sd_side_reg.ch;
            sec1_reg  <= sec_reg;
            tn1_reg   <= tn_reg;
            dec1_reg  <= sd_side_reg.dec;
            ra1_reg   <= sd_side_reg.ra;
            mode1_reg <= sd_side_reg.mode;
            sat1_reg  <= sd_side_reg.sat;
        end
    end

    // stage 2: second-level products and partial sums
    logic signed [31:0] q1_reg, q3_reg, p5b_reg, sec2_reg, tn2_reg, dec2_reg;
    logic signed [32:0] d2_reg, s9_reg;
    logic signed [33:0] add_dd2_reg;
    logic [31:0]        add_dr2_reg, ra2_reg;
    logic               mode2_reg, sat2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_reg      <= 32'(epc_pkg::mul_rnd(64'(p4_reg), 64'(ch1_reg), 30));
            q3_reg      <= 32'(epc_pkg::mul_rnd(64'(tf_reg), 64'(p8_reg), 30));
            d2_reg      <= 33'(p6_reg) - 33'(p7_reg);
            s9_reg      <= 33'(p9_reg) + 33'(p10_reg);
            add_dd2_reg <= 34'(ixd_reg) + 34'(p1_reg) + 34'(p2_reg) + 34'(p3_reg);
            add_dr2_reg <= ixr_reg + p11_reg + p12_reg;
            p5b_reg     <= p5_reg;
            sec2_reg    <= sec1_reg;
            tn2_reg     <= tn1_reg;
            dec2_reg    <= dec1_reg;
            ra2_reg     <= ra1_reg;
            mode2_reg   <= mode1_reg;
            sat2_reg    <= sat1_reg;
        end
    end

    // stage 3: products against secant and tangent
    logic signed [32:0] e1_reg;
    logic [31:0]        r2_reg, r3_reg, r4_reg, add_dr3_reg, ra3_reg;
    logic signed [33:0] add_dd3_reg;
    logic signed [31:0] dec3_reg;
    logic               mode3_reg, sat3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg      <= 33'(q1_reg) - 33'(p5b_reg);
            r2_reg      <= 32'(epc_pkg::mul_rnd(64'(d2_reg), 64'(tn2_reg), 24));
            r3_reg      <= 32'(epc_pkg::mul_rnd(64'(q3_reg), 64'(sec2_reg), 24));
            r4_reg      <= 32'(epc_pkg::mul_rnd(64'(fo_reg), 64'(s9_reg), 24));
            add_dd3_reg <= add_dd2_reg;
            add_dr3_reg <= add_dr2_reg;
            dec3_reg    <= dec2_reg;
            ra3_reg     <= ra2_reg;
            mode3_reg   <= mode2_reg;
            sat3_reg    <= sat2_reg;
        end
    end

    // stage 4: tube flexure product and ra term sum
    logic signed [32:0] f1_reg;
    logic signed [33:0] add_dd4_reg;
    logic [31:0]        dr4_reg, ra4_reg;
    logic signed [31:0] dec4_reg;
    logic               mode4_reg, sat4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg      <= 33'(epc_pkg::mul_rnd(64'(tf_reg), 64'(e1_reg), 30));
            dr4_reg     <= add_dr3_reg + r2_reg + r3_reg + r4_reg;
            add_dd4_reg <= add_dd3_reg;
            dec4_reg    <= dec3_reg;
            ra4_reg     <= ra3_reg;
            mode4_reg   <= mode3_reg;
            sat4_reg    <= sat3_reg;
        end
    end

    // valid bits of the multiply stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sg_valid_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
        end else if (en) begin
            sg_valid_reg <= dval[QW];
            v1_reg       <= sg_valid_reg;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
        end
    end

    // final apply or reverse with declination clamp
    epc_pkg::out_t fin_data;
    logic signed [34:0] dd_w;
    logic signed [35:0] r_w;

    always_comb begin
        dd_w = 35'(add_dd4_reg) + 35'(f1_reg);
        r_w  = mode4_reg ? (36'(dec4_reg) + 36'(dd_w)) : (36'(dec4_reg) - 36'(dd_w));
        if (r_w > 36'sd2147483647) begin
            fin_data.corrected_dec = 32'sh7FFF_FFFF;
        end else if (r_w < -36'sd2147483648) begin
            fin_data.corrected_dec = 32'sh8000_0000;
        end else begin
            fin_data.corrected_dec = 32'(r_w);
        end
        fin_data.corrected_ra   = mode4_reg ? (ra4_reg + dr4_reg) : (ra4_reg - dr4_reg);
        fin_data.pole_saturated = sat4_reg;
    end

    // output register and skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (v4_reg) begin
            if (m_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (v4_reg) begin
            if (m_valid_reg && !m_ready) begin
                skid_data_reg <= fin_data;
            end else begin
                m_data_reg <= fin_data;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `EPC_ASSERT_ALWAYS(a_skid_needs_out, skid_valid_reg |-> m_valid_reg)
    `EPC_ASSERT(a_skid_only_on_stall, $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
    `EPC_ASSERT(a_accept_enters_row, (s_valid && s_ready) |=> cval[1])

endmodule

// ===== sv/epc_cordic_cell.sv =====
// one rotation step for the hour, declination and latitude angles
// depends on epc_pkg
module epc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  epc_pkg::crow_t in_row,
    output logic          out_valid,
    output epc_pkg::crow_t out_row
);

    localparam logic signed [epc_pkg::ROT_W-1:0] ATAN =
        $signed({2'b00, epc_pkg::atan_turn(STAGE)});

    logic           valid_reg;
    epc_pkg::crow_t row_reg;
    epc_pkg::crow_t row_next;

    function automatic epc_pkg::rot_t step(input epc_pkg::rot_t r);
        epc_pkg::rot_t o;
        o = r;
        if (r.z >= 0) begin
            o.x = r.x - (r.y >>> STAGE);
            o.y = r.y + (r.x >>> STAGE);
            o.z = r.z - ATAN;
        end else begin
            o.x = r.x + (r.y >>> STAGE);
            o.y = r.y - (r.x >>> STAGE);
            o.z = r.z + ATAN;
        end
        return o;
    endfunction

    // rotate all three vectors
    always_comb begin
        row_next   = in_row;
        row_next.h = step(in_row.h);
        row_next.d = step(in_row.d);
        row_next.p = step(in_row.p);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_reg <= row_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_row   = row_reg;

endmodule

// ===== sv/epc_div_cell.sv =====
// one quotient bit of the secant and tangent restoring dividers
// depends on epc_pkg
module epc_div_cell #(
    parameter int BIT = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  epc_pkg::drow_t in_row,
    output logic          out_valid,
    output epc_pkg::drow_t out_row
);

    logic           valid_reg;
    epc_pkg::drow_t row_reg;
    epc_pkg::drow_t row_next;
    logic [epc_pkg::REM_W-1:0] den_sh;

    // trial subtract of the shifted divisor
    always_comb begin
        row_next = in_row;
        den_sh   = epc_pkg::REM_W'(in_row.den) << BIT;
        if (in_row.rem_s >= den_sh) begin
            row_next.rem_s    = in_row.rem_s - den_sh;
            row_next.q_s[BIT] = 1'b1;
        end
        if (in_row.rem_t >= den_sh) begin
            row_next.rem_t    = in_row.rem_t - den_sh;
            row_next.q_t[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_reg <= row_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_row   = row_reg;

endmodule

// ===== sim/tb_equatorial_pointing_correction.sv =====
// self-checking testbench for the equatorial pointing correction block
// depends on epc_pkg and equatorial_pointing_correction; predicts every result in-line
`timescale 1ns / 100ps
module tb_equatorial_pointing_correction;

    localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;
    localparam int PIPE_DEPTH = epc_pkg::CORDIC_STAGES_DEF + 38;
    localparam int MAX_WAIT = 13;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    epc_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    epc_pkg::out_t m_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [63:0]   cfg_data;

    // model copy of the register file
    logic [63:0] mdl_index_offsets;
    logic [63:0] mdl_polar_axis;
    logic [63:0] mdl_flexure;
    logic [63:0] mdl_collimation;
    logic [31:0] mdl_fork;
    logic [31:0] mdl_latitude;

    epc_pkg::out_t expected_fixes[$];
    int   mismatches;
    bit   quiet;

    equatorial_pointing_correction DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // rounded product, floor shift
    function automatic longint rnd_mul(input longint a, input longint b, input int s);
        return (a * b + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint to_turns(input logic [31:0] half);
        longint c;
        c = longint'($signed(half));
        return rnd_mul(c, 64'sd1367130551, 32);
    endfunction

    function automatic logic [31:0] atan_lut(input int i);
        logic [31:0] lut [0:31];
        lut = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
                32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
                32'h00000001, 32'h00000000};
        return lut[i];
    endfunction

    // rotation cordic on a turn angle, Q30 cos and sin
    function automatic void rotate(input logic [31:0] ang, output longint cs,
                                   output longint sn);
        longint x, y, z, nx, t;
        bit flip;
        logic [31:0] a;
        a = ang;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) a = a + 32'h80000000;
        x = 652032874;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < epc_pkg::CORDIC_STAGES_DEF; i++) begin
            t = longint'(atan_lut(i));
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - t;
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + t;
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // corrected position for one pointing request
    function automatic epc_pkg::out_t correct_position(input epc_pkg::in_t req);
        epc_pkg::out_t res;
        longint ch, sh, cd, sd, cp, sp, ac, as_, sec, tn, dd, dr, r, q, t;
        longint ixd, ixr, pa1, pa2, tf, dc, co, np, fo;
        bit     sat;
        ixd = to_turns(mdl_index_offsets[63:32]);
        ixr = to_turns(mdl_index_offsets[31:0]);
        pa1 = to_turns(mdl_polar_axis[63:32]);
        pa2 = to_turns(mdl_polar_axis[31:0]);
        tf  = to_turns(mdl_flexure[63:32]);
        dc  = to_turns(mdl_flexure[31:0]);
        co  = to_turns(mdl_collimation[63:32]);
        np  = to_turns(mdl_collimation[31:0]);
        fo  = to_turns(mdl_fork);
        rotate(req.right_ascension, ch, sh);
        rotate(req.declination, cd, sd);
        rotate(mdl_latitude, cp, sp);
        ac = (cd < 0) ? -cd : cd;
        as_ = (sd < 0) ? -sd : sd;
        sat = ac < (longint'(1) <<< 24);
        // secant and tangent, clamped near the pole
        if (sat) begin
            sec = (cd < 0) ? -(longint'(1) <<< 30) : (longint'(1) <<< 30);
            tn = ((sd < 0) != (cd < 0)) ? -(longint'(1) <<< 30) : (longint'(1) <<< 30);
        end else begin
            q = ((longint'(1) <<< 54) + (ac >>> 1)) / ac;
            t = ((as_ <<< 24) + (ac >>> 1)) / ac;
            sec = (cd < 0) ? -q : q;
            tn = ((sd < 0) != (cd < 0)) ? -t : t;
        end
        dd = ixd + rnd_mul(pa1, ch, 30) + rnd_mul(pa2, sh, 30) + rnd_mul(dc, ch, 30)
           + rnd_mul(tf, rnd_mul(rnd_mul(cp, sd, 30), ch, 30) - rnd_mul(sp, cd, 30), 30);
        dr = ixr + rnd_mul(co, sec, 24) + rnd_mul(np, tn, 24)
           + rnd_mul(rnd_mul(pa1, sh, 30) - rnd_mul(pa2, ch, 30), tn, 24)
           + rnd_mul(rnd_mul(tf, rnd_mul(cp, sh, 30), 30), sec, 24)
           + rnd_mul(fo, rnd_mul(sp, tn, 30) + rnd_mul(cp, ch, 36), 24);
        r = req.mode ? longint'(req.declination) + dd : longint'(req.declination) - dd;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        res.corrected_ra = req.mode ? req.right_ascension + 32'(dr)
                                    : req.right_ascension - 32'(dr);
        res.corrected_dec = 32'(r);
        res.pole_saturated = sat;
        return res;
    endfunction

    // one position transaction, prediction taken at acceptance
    task automatic send_position(input logic mode, input logic [31:0] ra,
                                 input logic [31:0] dec);
        int gap;
        epc_pkg::in_t req;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        req.mode = mode;
        req.right_ascension = ra;
        req.declination = dec;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        expected_fixes.push_back(correct_position(req));
    endtask

    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_fixes.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
    endtask

    // register write, only called with the pipeline drained
    task automatic write_register(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            epc_pkg::CFG_INDEX_OFFSETS: mdl_index_offsets = val;
            epc_pkg::CFG_POLAR_AXIS:    mdl_polar_axis = val;
            epc_pkg::CFG_FLEXURE:       mdl_flexure = val;
            epc_pkg::CFG_COLLIMATION:   mdl_collimation = val;
            epc_pkg::CFG_FORK_FLEXURE:  mdl_fork = val[31:0];
            epc_pkg::CFG_SITE_LATITUDE: mdl_latitude = val[31:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_model(input logic [63:0] ix, input logic [63:0] pa,
                              input logic [63:0] fl, input logic [63:0] cl,
                              input logic [31:0] fo, input logic [31:0] lat);
        write_register(epc_pkg::CFG_INDEX_OFFSETS, ix);
        write_register(epc_pkg::CFG_POLAR_AXIS, pa);
        write_register(epc_pkg::CFG_FLEXURE, fl);
        write_register(epc_pkg::CFG_COLLIMATION, cl);
        write_register(epc_pkg::CFG_FORK_FLEXURE, {32'h0, fo});
        write_register(epc_pkg::CFG_SITE_LATITUDE, {32'h0, lat});
    endtask

    function automatic logic [31:0] small_coef();
        return $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 1 << 22))
               - (1 << 21));
    endfunction

    function automatic logic [31:0] pick_dec();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h40000000 - $urandom_range(0, 1 << 22);
            2: return 32'hC0000000 + $urandom_range(0, 1 << 22);
            default: return 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
        endcase
    endfunction

    // result handshake with random back-pressure
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        epc_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_fixes.size() == 0) begin
                mismatches++;
                $display("%t unexpected result %h", $realtime, m_data);
            end else begin
                want = expected_fixes.pop_front();
                if (m_data.corrected_ra !== want.corrected_ra) begin
                    mismatches++;
                    $display("%t corrected_ra expected %h actual %h", $realtime,
                             want.corrected_ra, m_data.corrected_ra);
                end
                if (m_data.corrected_dec !== want.corrected_dec) begin
                    mismatches++;
                    $display("%t corrected_dec expected %h actual %h", $realtime,
                             want.corrected_dec, m_data.corrected_dec);
                end
                if (m_data.pole_saturated !== want.pole_saturated) begin
                    mismatches++;
                    $display("%t pole_saturated expected %b actual %b", $realtime,
                             want.pole_saturated, m_data.pole_saturated);
                end
            end
        end
    end

    // zero model: corners of ra and declination, pole and past the pole
    task automatic test_zero_model();
        quiet = 1'b0;
        send_position(1'b0, 32'h00000000, 32'h00000000);
        send_position(1'b1, 32'hFFFFFFFF, 32'h40000000);
        send_position(1'b0, 32'h80000000, 32'hC0000000);
        send_position(1'b1, 32'h40000000, 32'h80000000);
        send_position(1'b0, 32'hC0000000, 32'h7FFFFFFF);
        send_position(1'b1, 32'h12345678, 32'h3F600000);
        drain_pipeline();
    endtask

    // extreme coefficients, saturated declination and pole clamp
    task automatic test_extreme_model();
        load_model(64'h7FFFFFFF_80000000, 64'h80000000_7FFFFFFF, 64'h7FFFFFFF_7FFFFFFF,
                   64'h80000000_80000000, 32'h7FFFFFFF, 32'h40000000);
        send_position(1'b0, 32'h00000000, 32'h40000000);
        send_position(1'b1, 32'hFFFFFFFF, 32'hC0000000);
        send_position(1'b0, 32'h20000000, 32'h3FFFFFFF);
        send_position(1'b1, 32'hA0000000, 32'h00000000);
        drain_pipeline();
        load_model(64'h80000000_7FFFFFFF, 64'h7FFFFFFF_80000000, 64'h80000000_80000000,
                   64'h7FFFFFFF_7FFFFFFF, 32'h80000000, 32'hC0000000);
        send_position(1'b1, 32'h00000000, 32'h3FFFFFFF);
        send_position(1'b0, 32'h7FFFFFFF, 32'hC0000001);
        send_position(1'b1, 32'h60000000, 32'h10000000);
        // unmapped register indexes leave the model alone
        drain_pipeline();
        write_register(CFG_UNMAPPED_LO, 64'hFFFFFFFF_FFFFFFFF);
        write_register(CFG_UNMAPPED_HI, 64'h12345678_9ABCDEF0);
        send_position(1'b0, 32'h55555555, 32'h2AAAAAAA);
        drain_pipeline();
    endtask

    // random positions over several random models
    task automatic test_random_models(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            load_model({small_coef(), small_coef()}, {small_coef(), small_coef()},
                       {small_coef(), small_coef()}, {small_coef(), small_coef()},
                       small_coef(), 32'($signed($urandom_range(0, 32'h80000000))
                       - 32'sh40000000));
            quiet = (p % 3 == 2);
            for (int i = 0; i < per_phase; i++)
                send_position($urandom_range(0, 1), $urandom(), pick_dec());
            drain_pipeline();
        end
        quiet = 1'b0;
    endtask

    // sender holds off until the pipeline is empty mid-stream
    task automatic test_hold_off();
        for (int i = 0; i < 20; i++)
            send_position($urandom_range(0, 1), $urandom(), pick_dec());
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_fixes.size() != 0) @(posedge aclk);
        for (int i = 0; i < 20; i++)
            send_position($urandom_range(0, 1), $urandom(), pick_dec());
        drain_pipeline();
    endtask

    initial begin
        mismatches = 0;
        quiet = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = epc_pkg::CFG_INDEX_OFFSETS;
        cfg_data = '0;
        mdl_index_offsets = '0;
        mdl_polar_axis = '0;
        mdl_flexure = '0;
        mdl_collimation = '0;
        mdl_fork = '0;
        mdl_latitude = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_zero_model();
        test_extreme_model();
        test_random_models(10, 115);
        test_hold_off();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
